// ----- sv/tlbpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared sizes, codes and inter-module structs for the TLB page translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int PAGE_BYTES  = 256;

  localparam int ADDR_W    = 16;
  localparam int OFFSET_W  = $clog2(PAGE_BYTES);
  localparam int PAGE_W    = ADDR_W - OFFSET_W;
  localparam int FRAME_W   = 8;
  localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
  localparam int ROW_W     = $clog2(PAGE_COUNT);
  localparam int CNT_W     = 32;

  typedef enum logic [1:0] {
    OUT_TLB_HIT   = 2'd0,
    OUT_TABLE_HIT = 2'd1,
    OUT_FAULT     = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  // tlb lookup answer
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } cam_rsp_t;

  // tlb fill on a miss
  typedef struct packed {
    logic               we;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } cam_wr_t;

  // page table read answer
  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } tbl_rsp_t;

  // page table write on a fault
  typedef struct packed {
    logic               we;
    logic [ROW_W-1:0]   row;
    logic [FRAME_W-1:0] frame;
  } tbl_wr_t;

endpackage

// ----- sv/tlbpt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_if
// Valid/ready channels for addresses in and translations out.
// ----------------------------------------------------------------------------
interface tlbpt_in_if;
  logic                         valid;
  logic                         ready;
  logic [tlbpt_pkg::ADDR_W-1:0] vaddr;

  modport source (output valid, output vaddr, input ready);
  modport sink   (input valid, input vaddr, output ready);
endinterface

interface tlbpt_out_if;
  logic                         valid;
  logic                         ready;
  logic [tlbpt_pkg::ADDR_W-1:0] paddr;
  logic [1:0]                   outcome;
  logic [tlbpt_pkg::CNT_W-1:0]  hit_count;
  logic [tlbpt_pkg::CNT_W-1:0]  fault_count;

  modport source (output valid, output paddr, output outcome,
                  output hit_count, output fault_count, input ready);
  modport sink   (input valid, input paddr, input outcome,
                  input hit_count, input fault_count, output ready);
endinterface

// ----- sv/tlbpt_cam.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_cam
// Fully associative TLB with FIFO replacement pointer.
// ----------------------------------------------------------------------------
module tlbpt_cam (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [tlbpt_pkg::PAGE_W-1:0] page,
  output tlbpt_pkg::cam_rsp_t          rsp,
  input  tlbpt_pkg::cam_wr_t           wr
);

  logic [tlbpt_pkg::PAGE_W-1:0]    tag_r   [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::FRAME_W-1:0]   frame_r [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::TLB_ENTRIES-1:0] valid_r;
  logic [tlbpt_pkg::TLB_IDX_W-1:0] ptr_r;
  logic [tlbpt_pkg::TLB_IDX_W-1:0] ptr_nxt;

  // lowest matching entry wins
  always_comb begin
    rsp = '0;
    for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
      if (!rsp.hit && valid_r[i] && tag_r[i] == page) begin
        rsp.hit   = 1'b1;
        rsp.frame = frame_r[i];
      end
    end
  end

  always_comb begin
    if (ptr_r == tlbpt_pkg::TLB_IDX_W'(tlbpt_pkg::TLB_ENTRIES - 1)) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ptr_r   <= '0;
    end else if (wr.we) begin
      valid_r[ptr_r] <= 1'b1;
      ptr_r          <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      tag_r[ptr_r]   <= wr.page;
      frame_r[ptr_r] <= wr.frame;
    end
  end

endmodule

// ----- sv/tlbpt_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_table
// Page table: synchronous frame memory plus per-row valid flops.
// ----------------------------------------------------------------------------
module tlbpt_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [tlbpt_pkg::ROW_W-1:0] rd_row,
  output tlbpt_pkg::tbl_rsp_t         rsp,
  input  tlbpt_pkg::tbl_wr_t          wr
);

  logic [tlbpt_pkg::FRAME_W-1:0]    mem [tlbpt_pkg::PAGE_COUNT];
  logic [tlbpt_pkg::PAGE_COUNT-1:0] valid_r;
  logic [tlbpt_pkg::FRAME_W-1:0]    rd_frame_r;
  logic                             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.row] <= wr.frame;
    end
    if (rd_en) begin
      rd_frame_r <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.we) begin
        valid_r[wr.row] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_row];
      end
    end
  end

  assign rsp.valid = rd_valid_r;
  assign rsp.frame = rd_frame_r;

endmodule

// ----- sv/tlb_page_table_translator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Translates 16-bit logical addresses through a TLB backed by a page table.
// ----------------------------------------------------------------------------
// in_ch carries one logical address per item, out_ch one translation per item:
// physical address, outcome (tlb hit, table hit, fault) and saturating running
// counts of tlb hits and faults that include the item itself.
// An item passes the idle and lookup states: the accept cycle issues the page
// table read; the lookup state compares the page against all tlb entries, uses
// the registered table word, updates table and tlb and loads the output
// register. The registered table read sets this split; one item is in flight.
// The block takes a new address while the previous result still sits in the
// output register, once the lookup state has released the previous item.
// If the receiver stalls, the finished item holds in the output register and
// the next item waits in the lookup stage until the register frees up.
// Synchronous reset empties the tlb and the page table (valid flops only),
// zeroes the replacement pointer and both counters; no clearing pass is run.
// ----------------------------------------------------------------------------
module tlb_page_table_translator (
  input  logic clk,
  input  logic rst_n,
  tlbpt_in_if.sink    in_ch,
  tlbpt_out_if.source out_ch
);

  tlbpt_pkg::state_t state_r, state_nxt;
  logic [tlbpt_pkg::ADDR_W-1:0]  addr_r;
  logic [tlbpt_pkg::PAGE_W-1:0]  page;
  logic [tlbpt_pkg::OFFSET_W-1:0] offset;
  logic                          in_acc;
  logic                          finish;

  tlbpt_pkg::cam_rsp_t cam_rsp;
  tlbpt_pkg::cam_wr_t  cam_wr;
  tlbpt_pkg::tbl_rsp_t tbl_rsp;
  tlbpt_pkg::tbl_wr_t  tbl_wr;

  logic [tlbpt_pkg::FRAME_W-1:0] frame;
  tlbpt_pkg::outcome_t           outcome;

  logic                          out_valid_r;
  logic [tlbpt_pkg::ADDR_W-1:0]  out_pa_r;
  tlbpt_pkg::outcome_t           out_outcome_r;
  logic [tlbpt_pkg::CNT_W-1:0]   hits_r, hits_nxt;
  logic [tlbpt_pkg::CNT_W-1:0]   faults_r, faults_nxt;

  assign page   = addr_r[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFFSET_W];
  assign offset = addr_r[tlbpt_pkg::OFFSET_W-1:0];

  assign in_ch.ready = (state_r == tlbpt_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign finish      = (state_r == tlbpt_pkg::ST_LOOK) && (!out_valid_r || out_ch.ready);

  tlbpt_cam u_cam (
    .clk   (clk),
    .rst_n (rst_n),
    .page  (page),
    .rsp   (cam_rsp),
    .wr    (cam_wr)
  );

  tlbpt_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_acc),
    .rd_row (in_ch.vaddr[tlbpt_pkg::OFFSET_W +: tlbpt_pkg::ROW_W]),
    .rsp    (tbl_rsp),
    .wr     (tbl_wr)
  );

  always_comb begin
    if (cam_rsp.hit) begin
      frame   = cam_rsp.frame;
      outcome = tlbpt_pkg::OUT_TLB_HIT;
    end else if (tbl_rsp.valid) begin
      frame   = tbl_rsp.frame;
      outcome = tlbpt_pkg::OUT_TABLE_HIT;
    end else begin
      frame   = tlbpt_pkg::FRAME_W'(page);
      outcome = tlbpt_pkg::OUT_FAULT;
    end
  end

  // fill the tlb on any miss, the table only on a fault
  always_comb begin
    cam_wr.we    = finish && !cam_rsp.hit;
    cam_wr.page  = page;
    cam_wr.frame = frame;
    tbl_wr.we    = finish && (outcome == tlbpt_pkg::OUT_FAULT);
    tbl_wr.row   = page[tlbpt_pkg::ROW_W-1:0];
    tbl_wr.frame = frame;
  end

  always_comb begin
    hits_nxt   = hits_r;
    faults_nxt = faults_r;
    if (outcome == tlbpt_pkg::OUT_TLB_HIT && hits_r != '1) begin
      hits_nxt = hits_r + 1'b1;
    end
    if (outcome == tlbpt_pkg::OUT_FAULT && faults_r != '1) begin
      faults_nxt = faults_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlbpt_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = tlbpt_pkg::ST_LOOK;
        end
      end
      tlbpt_pkg::ST_LOOK: begin
        if (finish) begin
          state_nxt = tlbpt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tlbpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlbpt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      hits_r      <= '0;
      faults_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
        hits_r      <= hits_nxt;
        faults_r    <= faults_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r <= in_ch.vaddr;
    end
    if (finish) begin
      out_pa_r      <= {frame, offset};
      out_outcome_r <= outcome;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.paddr       = out_pa_r;
  assign out_ch.outcome     = out_outcome_r;
  assign out_ch.hit_count   = hits_r;
  assign out_ch.fault_count = faults_r;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the tlb page table translator. Addresses go in over a valid/ready
// channel and a class-based scoreboard keeps a copy of the tlb (fifo fill),
// page table and hit/fault counters, predicts each translation and checks the
// results in order. Directed corner addresses come first. Then random
// working-set bursts drive tlb hits, table hits after eviction, and faults.
// Both sides idle at random, and one long receiver stall backs up the block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 150;
  localparam int PHASE_ITEMS    = 600;

  typedef struct {
    logic [tlbpt_pkg::ADDR_W-1:0] phys_addr;
    tlbpt_pkg::outcome_t          outcome;
    logic [tlbpt_pkg::CNT_W-1:0]  hits;
    logic [tlbpt_pkg::CNT_W-1:0]  faults;
  } translation_t;

  class translation_scoreboard;
    logic [tlbpt_pkg::PAGE_W-1:0]  tlb_tag   [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::FRAME_W-1:0] tlb_frame [tlbpt_pkg::TLB_ENTRIES];
    bit                            tlb_valid [tlbpt_pkg::TLB_ENTRIES];
    int unsigned                   fill_ptr;
    logic [tlbpt_pkg::FRAME_W-1:0] tbl_frame [tlbpt_pkg::PAGE_COUNT];
    bit                            tbl_valid [tlbpt_pkg::PAGE_COUNT];
    logic [tlbpt_pkg::CNT_W-1:0]   hit_total;
    logic [tlbpt_pkg::CNT_W-1:0]   fault_total;
    translation_t                  expected_q[$];
    int                            error_count;

    function new();
      for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) tlb_valid[i] = 0;
      for (int i = 0; i < tlbpt_pkg::PAGE_COUNT; i++) tbl_valid[i] = 0;
      fill_ptr    = 0;
      hit_total   = '0;
      fault_total = '0;
      error_count = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // work out the translation of one accepted address and queue it
    function void note_address(logic [tlbpt_pkg::ADDR_W-1:0] addr);
      logic [tlbpt_pkg::PAGE_W-1:0]   page;
      logic [tlbpt_pkg::OFFSET_W-1:0] offset;
      logic [tlbpt_pkg::FRAME_W-1:0]  frame;
      int                             row;
      bit                             found;
      translation_t                   t;
      page   = addr[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFFSET_W];
      offset = addr[tlbpt_pkg::OFFSET_W-1:0];
      frame  = '0;
      found  = 0;
      for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
        if (!found && tlb_valid[i] && tlb_tag[i] == page) begin
          frame = tlb_frame[i];
          found = 1;
        end
      end
      if (found) begin
        t.outcome = tlbpt_pkg::OUT_TLB_HIT;
        if (hit_total != '1) hit_total = hit_total + 1'b1;
      end else begin
        row = int'(page) % tlbpt_pkg::PAGE_COUNT;
        if (tbl_valid[row]) begin
          frame     = tbl_frame[row];
          t.outcome = tlbpt_pkg::OUT_TABLE_HIT;
        end else begin
          frame          = tlbpt_pkg::FRAME_W'(page);
          tbl_frame[row] = frame;
          tbl_valid[row] = 1;
          t.outcome      = tlbpt_pkg::OUT_FAULT;
          if (fault_total != '1) fault_total = fault_total + 1'b1;
        end
        tlb_tag[fill_ptr]   = page;
        tlb_frame[fill_ptr] = frame;
        tlb_valid[fill_ptr] = 1;
        fill_ptr            = (fill_ptr + 1) % tlbpt_pkg::TLB_ENTRIES;
      end
      t.phys_addr = tlbpt_pkg::ADDR_W'(int'(frame) * tlbpt_pkg::PAGE_BYTES + int'(offset));
      t.hits      = hit_total;
      t.faults    = fault_total;
      expected_q.push_back(t);
    endfunction

    function void check_translation(logic [tlbpt_pkg::ADDR_W-1:0] phys_addr,
                                    logic [1:0] outcome,
                                    logic [tlbpt_pkg::CNT_W-1:0] hits,
                                    logic [tlbpt_pkg::CNT_W-1:0] faults);
      translation_t t;
      if (expected_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: unexpected result phys=%h outcome=%0d hits=%0d faults=%0d",
                   $realtime, phys_addr, outcome, hits, faults);
        return;
      end
      t = expected_q.pop_front();
      if (phys_addr !== t.phys_addr || outcome !== t.outcome ||
          hits !== t.hits || faults !== t.faults) begin
        error_count++;
        if (error_count <= 10) begin
          $display("%0t: mismatch exp phys=%h outcome=%0d hits=%0d faults=%0d",
                   $realtime, t.phys_addr, t.outcome, t.hits, t.faults);
          $display("%0t: mismatch got phys=%h outcome=%0d hits=%0d faults=%0d",
                   $realtime, phys_addr, outcome, hits, faults);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tlbpt_in_if  in_ch();
  tlbpt_out_if out_ch();

  tlb_page_table_translator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  translation_scoreboard xlate_sb = new();

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_token  = 0;

  // sample both channels at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) xlate_sb.note_address(in_ch.vaddr);
      if (out_ch.valid && out_ch.ready)
        xlate_sb.check_translation(out_ch.paddr, out_ch.outcome,
                                   out_ch.hit_count, out_ch.fault_count);
    end
  end

  // receiver: random ready, plus a long hold when asked
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  task automatic send_address(logic [tlbpt_pkg::ADDR_W-1:0] addr);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.vaddr <= addr;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // bursts over a small page working set; set sizes above the tlb depth force
  // evictions so revisits become table hits
  task automatic run_traffic(int tx_pct, int rx_pct, int count);
    logic [tlbpt_pkg::PAGE_W-1:0] work_pages [24];
    int                           set_size;
    int                           burst_len;
    int                           sent;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        send_address(tlbpt_pkg::ADDR_W'($urandom));
        sent++;
      end else begin
        set_size  = $urandom_range(24, 1);
        burst_len = $urandom_range(40, 8);
        for (int k = 0; k < set_size; k++) begin
          case ($urandom_range(7))
            0:       work_pages[k] = '0;
            1:       work_pages[k] = '1;
            default: work_pages[k] = tlbpt_pkg::PAGE_W'($urandom);
          endcase
        end
        for (int j = 0; j < burst_len && sent < count; j++) begin
          send_address({work_pages[$urandom_range(set_size - 1)],
                        tlbpt_pkg::OFFSET_W'($urandom)});
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.vaddr <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 17;
    rx_idle_pct = 46;
    // corners: extreme pages and offsets, fault then tlb hit on the same page
    send_address(16'h0000);
    send_address(16'h00FF);
    send_address(16'hFFFF);
    send_address(16'hFF00);
    send_address(16'hAA55);
    send_address(16'h55AA);
    // sixteen new pages wrap the fill pointer and evict the early entries
    for (int p = 1; p <= 16; p++) send_address({8'(p), 8'(p * 13)});
    // evicted pages now come back from the page table
    send_address(16'h0012);
    send_address(16'hFF80);

    run_traffic(17, 46, PHASE_ITEMS);
    run_traffic(46, 17, PHASE_ITEMS);
    // long receiver stall while the sender keeps offering
    hold_token++;
    run_traffic(0, 0, PHASE_ITEMS);
    in_ch.valid <= 1'b0;

    while (xlate_sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (xlate_sb.error_count == 0 && xlate_sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- tlb_page_table_translator.f -----
sv/tlbpt_pkg.sv
sv/tlbpt_if.sv
sv/tlbpt_cam.sv
sv/tlbpt_table.sv
sv/tlb_page_table_translator.sv
bench/tb_top.sv
